@@ hw/rtl/murmur3_32_stream_hash_unit_assert.svh @@
// Assertion macros for the MurmurHash3 stream hash unit
`ifndef MURMUR3_32_STREAM_HASH_UNIT_ASSERT_SVH
`define MURMUR3_32_STREAM_HASH_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MM3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MM3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mm3_pkg.sv @@
// Package: MurmurHash3 constants, command struct and byte mask helper
`timescale 1ns / 1ps

package mm3_pkg;

  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

  localparam logic [2:0] FULL_BYTES = 3'd4;
  localparam logic [31:0] SEED_RESET = 32'h0;

  // datapath commands, at most one step per cycle
  typedef struct packed {
    logic load;       // request taken: first multiply, length update
    logic load_seed;  // start of message: accumulator from seed
    logic mul2;       // second scramble multiply
    logic mix;        // accumulator update
    logic mix_last;   // last word: fold in length and first avalanche shift
    logic fin1;       // first avalanche multiply
    logic fin2;       // second avalanche multiply, result register load
  } cmd_t;

  function automatic logic [31:0] byte_mask(input logic [2:0] count);
    logic [31:0] m;
    case (count)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

@@ hw/rtl/mm3_datapath.sv @@
// Datapath: seed, accumulator, length, shared 32x32 multiplier, result register
`timescale 1ns / 1ps

module mm3_datapath #(
  parameter logic [31:0] SEED_INIT = mm3_pkg::SEED_RESET
) (
  input  logic             clk,
  input  logic             rst,
  input  mm3_pkg::cmd_t    cmd,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  input  logic [31:0]      message_word,
  input  logic [2:0]       byte_count,
  input  logic             last_word,
  output logic [31:0]      hash_value
);
  import mm3_pkg::*;

  logic [31:0] seed;
  logic [31:0] acc;
  logic [31:0] len;
  logic [31:0] k;
  logic        full;

  logic [2:0]  cnt_eff;
  logic [31:0] len_next;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic [31:0] hx;
  logic [31:0] hr;
  logic [31:0] hm;
  logic [31:0] hl;
  logic [31:0] acc_x13;

  always_comb begin
    if (!last_word || byte_count > FULL_BYTES) begin
      cnt_eff = FULL_BYTES;
    end else begin
      cnt_eff = byte_count;
    end
  end

  assign len_next = (cmd.load_seed ? 32'h0 : len) + {29'h0, cnt_eff};

  assign acc_x13 = acc ^ (acc >> 13);

  always_comb begin
    if (cmd.mul2) begin
      mul_a = {k[16:0], k[31:17]};
      mul_b = MIX_C2;
    end else if (cmd.fin1) begin
      mul_a = acc;
      mul_b = FIN_C1;
    end else if (cmd.fin2) begin
      mul_a = acc_x13;
      mul_b = FIN_C2;
    end else begin
      mul_a = message_word & byte_mask(cnt_eff);
      mul_b = MIX_C1;
    end
  end

  assign prod = mul_a * mul_b;

  assign hx = acc ^ k;
  assign hr = {hx[18:0], hx[31:19]};
  assign hm = full ? ((hr << 2) + hr + MIX_ADD) : hx;
  assign hl = hm ^ len;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_INIT;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 32'h0;
      len <= 32'h0;
    end else begin
      if (cmd.load) begin
        len <= len_next;
        if (cmd.load_seed) begin
          acc <= seed;
        end
      end else if (cmd.mix) begin
        acc <= cmd.mix_last ? (hl ^ (hl >> 16)) : hm;
      end else if (cmd.fin1) begin
        acc <= prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k    <= prod;
      full <= cnt_eff[2];
    end else if (cmd.mul2) begin
      k <= prod;
    end
    if (cmd.fin2) begin
      hash_value <= prod ^ (prod >> 16);
    end
  end

endmodule

@@ hw/rtl/mm3_ctrl.sv @@
// Controller: step sequencer, message tracking and output handshake
`timescale 1ns / 1ps

module mm3_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          last_word,
  output logic          out_valid,
  input  logic          out_ready,
  output mm3_pkg::cmd_t cmd
);
  import mm3_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL2 = 5'b00010,
    S_MIX  = 5'b00100,
    S_FIN1 = 5'b01000,
    S_FIN2 = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   mid_message;
  logic   last_q;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_MUL2;
        end
      end
      S_MUL2: state_next = S_MIX;
      S_MIX:  state_next = last_q ? S_FIN1 : S_IDLE;
      S_FIN1: state_next = S_FIN2;
      S_FIN2: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.load_seed = accept && !mid_message;
    cmd.mul2      = (state == S_MUL2);
    cmd.mix       = (state == S_MIX);
    cmd.mix_last  = (state == S_MIX) && last_q;
    cmd.fin1      = (state == S_FIN1);
    cmd.fin2      = (state == S_FIN2) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mid_message <= 1'b0;
      last_q      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        mid_message <= !last_word;
        last_q      <= last_word;
      end
      if (cmd.fin2) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/murmur3_32_stream_hash_unit.sv @@
// MurmurHash3 x86_32 over a stream of 32-bit little-endian words
// Input channel (in_valid/in_ready): message_word, byte_count, last_word.
// byte_count (0..4, above 4 means 4) only matters on the last word.
// Output channel (out_valid/out_ready): hash_value, one per message.
// cfg_we/cfg_wdata write the seed; it applies from the next message start.
// Words that are not last pass through accept, second scramble multiply
// and accumulator mix, and no new request is taken until they finish;
// this is bounded by the single shared 32x32 multiplier. A last word also
// takes two more avalanche multiplies on the same multiplier, after
// which hash_value is registered and out_valid is set.
// The result sits in an output register, so the next message can start
// while it waits. If the receiver stalls and a new hash is ready, the
// block holds in its final step and takes no request until the register
// frees up.
// Reset: synchronous; seed back to SEED_INIT (0 by default), no message open, output empty.
`timescale 1ns / 1ps

module murmur3_32_stream_hash_unit #(
  parameter logic [31:0] SEED_INIT = mm3_pkg::SEED_RESET
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] message_word,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value
);
  import mm3_pkg::*;

  cmd_t       cmd;
  logic [4:0] step_vec;

  mm3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_word (last_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mm3_datapath #(
    .SEED_INIT (SEED_INIT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .message_word (message_word),
    .byte_count   (byte_count),
    .last_word    (last_word),
    .hash_value   (hash_value)
  );

  assign step_vec = {cmd.load, cmd.mul2, cmd.mix, cmd.fin1, cmd.fin2};

`include "murmur3_32_stream_hash_unit_assert.svh"

  `MM3_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted twice in a row")
  `MM3_ASSERT_NOW(a_one_step, 1'b1, $onehot0(step_vec), "more than one datapath step at once")
  `MM3_ASSERT_NEXT(a_result_loaded, cmd.fin2, out_valid, "finished hash not presented")
  `MM3_ASSERT_NOW(a_no_overwrite, out_valid && !out_ready, !cmd.fin2, "pending hash overwritten")

endmodule
